>>> rtl/core/cvfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the channel vocoder filter bank.
package cvfb_pkg;

    // Fixed formats of the block
    localparam int BANDS       = 24;
    localparam int BAND_W      = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int ENV_BITS    = 24;
    localparam int GAIN_BITS   = 23;
    localparam int CFG_W       = 24;

    // Request codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Coefficient selects
    localparam logic [1:0] CSEL_B0 = 2'd0;
    localparam logic [1:0] CSEL_A1 = 2'd1;
    localparam logic [1:0] CSEL_A2 = 2'd2;

    // Register indexes
    localparam logic CFG_ENV_COEF = 1'b0;
    localparam logic CFG_GAIN     = 1'b1;

    localparam logic [ENV_BITS-1:0]  ENV_COEF_RST = 24'd16759750;
    localparam logic [GAIN_BITS-1:0] GAIN_RST     = 23'd65536;

    // Operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MS_B0_DM,
        MS_A1_YM1,
        MS_A2_YM2,
        MS_C_ENV,
        MS_OM_RECT,
        MS_B0_DC,
        MS_A1_YC1,
        MS_A2_YC2,
        MS_YC_ENV,
        MS_SUMHI_G,
        MS_SUMLO_G
    } t_mul_sel;

    // Accumulator action
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_SHADD
    } t_acc_op;

    // Product scaling
    typedef enum logic [1:0] {
        SH_0,
        SH_23,
        SH_30
    } t_shift;

    typedef struct packed {
        t_mul_sel          mul_sel;
        t_acc_op           acc_op;
        t_shift            shift;
        logic              to_sum;
        logic              cap_ym;
        logic              cap_env;
        logic              cap_yc;
        logic              wr_band;
        logic              out_load;
        logic [BAND_W-1:0] band;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> rtl/core/cvfb_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that walks the bands of one sample pair through the datapath.
module cvfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_req_type,
    input  cvfb_pkg::t_dp_stat i_stat,
    output cvfb_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);
    import cvfb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MB0, S_MA1, S_MA2, S_ENV1, S_ENV2,
        S_CB0, S_CA1, S_CA2, S_CCAP, S_SUM, S_GHI, S_GLO, S_OUT
    } t_state;

    t_state            r_state;
    logic [BAND_W-1:0] r_band;

    // State and band counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_band  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept && i_req_type == REQ_SAMPLE) begin
                        r_band  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_MB0;
                S_MB0:  r_state <= S_MA1;
                S_MA1:  r_state <= S_MA2;
                S_MA2:  r_state <= S_ENV1;
                S_ENV1: r_state <= S_ENV2;
                S_ENV2: r_state <= S_CB0;
                S_CB0:  r_state <= S_CA1;
                S_CA1:  r_state <= S_CA2;
                S_CA2:  r_state <= S_CCAP;
                S_CCAP: r_state <= S_SUM;
                S_SUM: begin
                    if (r_band == BAND_W'(BANDS - 1)) begin
                        r_state <= S_GHI;
                    end else begin
                        r_band  <= r_band + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_GHI:  r_state <= S_GLO;
                S_GLO:  r_state <= S_OUT;
                S_OUT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command decode
    always_comb begin
        o_cmd.mul_sel  = MS_B0_DM;
        o_cmd.acc_op   = ACC_HOLD;
        o_cmd.shift    = SH_0;
        o_cmd.to_sum   = 1'b0;
        o_cmd.cap_ym   = 1'b0;
        o_cmd.cap_env  = 1'b0;
        o_cmd.cap_yc   = 1'b0;
        o_cmd.wr_band  = 1'b0;
        o_cmd.out_load = 1'b0;
        o_cmd.band     = r_band;
        unique case (r_state)
            S_MB0: begin
                o_cmd.mul_sel = MS_B0_DM;  o_cmd.acc_op = ACC_LOAD; o_cmd.shift = SH_30;
            end
            S_MA1: begin
                o_cmd.mul_sel = MS_A1_YM1; o_cmd.acc_op = ACC_SUB;  o_cmd.shift = SH_30;
            end
            S_MA2: begin
                o_cmd.mul_sel = MS_A2_YM2; o_cmd.acc_op = ACC_SUB;  o_cmd.shift = SH_30;
            end
            S_ENV1: begin
                o_cmd.mul_sel = MS_C_ENV;  o_cmd.acc_op = ACC_LOAD; o_cmd.cap_ym = 1'b1;
            end
            S_ENV2: begin
                o_cmd.mul_sel = MS_OM_RECT; o_cmd.acc_op = ACC_ADD;
            end
            S_CB0: begin
                o_cmd.mul_sel = MS_B0_DC;  o_cmd.acc_op = ACC_LOAD; o_cmd.shift = SH_30;
                o_cmd.cap_env = 1'b1;
            end
            S_CA1: begin
                o_cmd.mul_sel = MS_A1_YC1; o_cmd.acc_op = ACC_SUB;  o_cmd.shift = SH_30;
            end
            S_CA2: begin
                o_cmd.mul_sel = MS_A2_YC2; o_cmd.acc_op = ACC_SUB;  o_cmd.shift = SH_30;
            end
            S_CCAP: o_cmd.cap_yc = 1'b1;
            S_SUM: begin
                o_cmd.mul_sel = MS_YC_ENV; o_cmd.shift = SH_23;
                o_cmd.to_sum  = 1'b1;      o_cmd.wr_band = 1'b1;
            end
            S_GHI: begin
                o_cmd.mul_sel = MS_SUMHI_G; o_cmd.acc_op = ACC_LOAD;
            end
            S_GLO: begin
                o_cmd.mul_sel = MS_SUMLO_G; o_cmd.acc_op = ACC_SHADD;
            end
            S_OUT: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/core/cvfb_dp.sv
`timescale 1ns / 1ps
// Datapath: coefficient and band state memories, shared multiply-accumulate, output register.
module cvfb_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_idx,
    input  logic [cvfb_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_accept,
    input  logic [1:0]                              i_req_type,
    input  logic signed [cvfb_pkg::SAMPLE_BITS-1:0] i_modulator_in,
    input  logic signed [cvfb_pkg::SAMPLE_BITS-1:0] i_carrier_in,
    input  logic [cvfb_pkg::BAND_W-1:0]             i_coef_band,
    input  logic [1:0]                              i_coef_select,
    input  logic signed [cvfb_pkg::COEF_BITS-1:0]   i_coef_value,
    input  cvfb_pkg::t_dp_cmd                       i_cmd,
    output cvfb_pkg::t_dp_stat                      o_stat,
    input  logic                                    i_out_stall,
    output logic                                    o_out_valid,
    output logic signed [cvfb_pkg::SAMPLE_BITS-1:0] o_vocoded_out,
    output logic                                    o_clipped
);
    import cvfb_pkg::*;

    localparam int OP_W   = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 70;
    localparam int SUM_W  = 46;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int FIN_W  = ACC_W - 16;

    typedef struct packed {
        logic signed [31:0] ym1;
        logic signed [31:0] ym2;
        logic signed [31:0] yc1;
        logic signed [31:0] yc2;
        logic [31:0]        env;
    } t_band_row;

    logic [ENV_BITS-1:0]           r_env_coef;
    logic [GAIN_BITS-1:0]          r_gain;
    logic signed [SAMPLE_BITS-1:0] r_xm1, r_xm2, r_xc1, r_xc2;
    logic signed [DIFF_W-1:0]      r_dm, r_dc;

    logic signed [COEF_BITS-1:0] r_b0_mem [BANDS];
    logic signed [COEF_BITS-1:0] r_a1_mem [BANDS];
    logic signed [COEF_BITS-1:0] r_a2_mem [BANDS];
    t_band_row                   r_row_mem [BANDS];
    logic [BANDS-1:0]            r_b0_vld, r_a1_vld, r_a2_vld, r_row_vld;

    logic signed [COEF_BITS-1:0] r_b0_rd, r_a1_rd, r_a2_rd;
    t_band_row                   r_row_rd;
    logic                        r_b0_rv, r_a1_rv, r_a2_rv, r_row_rv;

    logic signed [ACC_W-1:0]       r_acc;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [31:0]            r_ymn, r_ycn;
    logic [31:0]                   r_envn;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;
    logic                          r_clip;

    logic signed [COEF_BITS-1:0] b0, a1, a2;
    t_band_row                   row;
    logic                        take_sample, take_clear, coef_wr;
    logic [24:0]                 one_minus;
    logic [31:0]                 rect;
    logic signed [OP_W-1:0]      a_op, b_op;
    logic signed [PROD_W-1:0]    prod, prod_sh;
    logic signed [ACC_W-1:0]     term;
    logic signed [31:0]          y_sat;
    logic signed [FIN_W-1:0]     fin;
    logic                        fin_fit;
    logic signed [SAMPLE_BITS-1:0] fin_sat;

    assign take_sample = i_accept && (i_req_type == REQ_SAMPLE);
    assign take_clear  = i_accept && (i_req_type == REQ_CLEAR);
    assign coef_wr     = i_accept && (i_req_type == REQ_COEF)
                         && (i_coef_band < BAND_W'(BANDS)) && (i_coef_select != 2'd3);

    // Configuration registers, input histories and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_coef <= ENV_COEF_RST;
            r_gain     <= GAIN_RST;
            r_xm1 <= '0; r_xm2 <= '0; r_xc1 <= '0; r_xc2 <= '0;
            r_b0_vld <= '0; r_a1_vld <= '0; r_a2_vld <= '0; r_row_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENV_COEF: r_env_coef <= i_cfg_data;
                    CFG_GAIN:     r_gain     <= i_cfg_data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (take_sample) begin
                r_xm2 <= r_xm1; r_xm1 <= i_modulator_in;
                r_xc2 <= r_xc1; r_xc1 <= i_carrier_in;
            end
            if (take_clear) begin
                r_xm1 <= '0; r_xm2 <= '0; r_xc1 <= '0; r_xc2 <= '0;
                r_row_vld <= '0;
            end
            if (coef_wr) begin
                unique case (i_coef_select)
                    CSEL_B0: r_b0_vld[i_coef_band] <= 1'b1;
                    CSEL_A1: r_a1_vld[i_coef_band] <= 1'b1;
                    CSEL_A2: r_a2_vld[i_coef_band] <= 1'b1;
                    default: ;
                endcase
            end
            if (i_cmd.wr_band) r_row_vld[i_cmd.band] <= 1'b1;
        end
    end

    // Input differences x - x2 for the band filters
    always_ff @(posedge i_clk) begin
        if (take_sample) begin
            r_dm <= DIFF_W'(i_modulator_in) - DIFF_W'(r_xm2);
            r_dc <= DIFF_W'(i_carrier_in) - DIFF_W'(r_xc2);
        end
    end

    // Coefficient memories
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            case (i_coef_select)
                CSEL_B0: r_b0_mem[i_coef_band] <= i_coef_value;
                CSEL_A1: r_a1_mem[i_coef_band] <= i_coef_value;
                CSEL_A2: r_a2_mem[i_coef_band] <= i_coef_value;
                default: ;
            endcase
        end
        r_b0_rd <= r_b0_mem[i_cmd.band];
        r_a1_rd <= r_a1_mem[i_cmd.band];
        r_a2_rd <= r_a2_mem[i_cmd.band];
        r_b0_rv <= r_b0_vld[i_cmd.band];
        r_a1_rv <= r_a1_vld[i_cmd.band];
        r_a2_rv <= r_a2_vld[i_cmd.band];
    end

    // Band state memory: filter histories and envelope
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_band) begin
            r_row_mem[i_cmd.band] <= '{ym1: r_ymn, ym2: row.ym1,
                                       yc1: r_ycn, yc2: row.yc1, env: r_envn};
        end
        r_row_rd <= r_row_mem[i_cmd.band];
        r_row_rv <= r_row_vld[i_cmd.band];
    end

    // Entries never written read as zero
    assign b0  = r_b0_rv  ? r_b0_rd  : '0;
    assign a1  = r_a1_rv  ? r_a1_rd  : '0;
    assign a2  = r_a2_rv  ? r_a2_rd  : '0;
    assign row = r_row_rv ? r_row_rd : '0;

    assign one_minus = 25'h1000000 - {1'b0, r_env_coef};
    assign rect      = r_ymn[31] ? (~r_ymn + 32'd1) : r_ymn;

    // Multiplier operand selection
    always_comb begin
        a_op = '0;
        b_op = '0;
        case (i_cmd.mul_sel)
            MS_B0_DM:   begin a_op = OP_W'(b0); b_op = OP_W'(r_dm);        end
            MS_A1_YM1:  begin a_op = OP_W'(a1); b_op = OP_W'(row.ym1);     end
            MS_A2_YM2:  begin a_op = OP_W'(a2); b_op = OP_W'(row.ym2);     end
            MS_C_ENV:   begin a_op = {9'd0, r_env_coef}; b_op = {1'b0, row.env}; end
            MS_OM_RECT: begin a_op = {8'd0, one_minus};  b_op = {1'b0, rect};    end
            MS_B0_DC:   begin a_op = OP_W'(b0); b_op = OP_W'(r_dc);        end
            MS_A1_YC1:  begin a_op = OP_W'(a1); b_op = OP_W'(row.yc1);     end
            MS_A2_YC2:  begin a_op = OP_W'(a2); b_op = OP_W'(row.yc2);     end
            MS_YC_ENV:  begin a_op = OP_W'(r_ycn); b_op = {1'b0, r_envn};  end
            MS_SUMHI_G: begin
                a_op = OP_W'($signed(r_sum[SUM_W-1:23])); b_op = {10'd0, r_gain};
            end
            MS_SUMLO_G: begin a_op = {10'd0, r_sum[22:0]};     b_op = {10'd0, r_gain}; end
            default: ;
        endcase
    end

    // Shared multiplier and product scaling (floor)
    assign prod = a_op * b_op;
    always_comb begin
        case (i_cmd.shift)
            SH_23:   prod_sh = prod >>> 23;
            SH_30:   prod_sh = prod >>> 30;
            default: prod_sh = prod;
        endcase
    end
    assign term = {{(ACC_W - PROD_W){prod_sh[PROD_W-1]}}, prod_sh};

    // Filter output saturated to 32 bits
    assign y_sat = (r_acc[ACC_W-1:31] == {(ACC_W - 31){r_acc[31]}}) ? r_acc[31:0]
                 : (r_acc[ACC_W-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}});

    // Accumulator, band sum and captured intermediates
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            ACC_LOAD:  r_acc <= term;
            ACC_ADD:   r_acc <= r_acc + term;
            ACC_SUB:   r_acc <= r_acc - term;
            ACC_SHADD: r_acc <= (r_acc <<< 23) + term;
            default:   ;
        endcase
        if (take_sample)       r_sum <= '0;
        else if (i_cmd.to_sum) r_sum <= r_sum + term[SUM_W-1:0];
        if (i_cmd.cap_ym)  r_ymn  <= y_sat;
        if (i_cmd.cap_yc)  r_ycn  <= y_sat;
        if (i_cmd.cap_env) r_envn <= r_acc[55:24];
    end

    // Gain scaling back to the sample format, with saturation
    assign fin     = r_acc[ACC_W-1:16];
    assign fin_fit = (fin[FIN_W-1:SAMPLE_BITS-1] == {(FIN_W - SAMPLE_BITS + 1){fin[SAMPLE_BITS-1]}});
    assign fin_sat = fin_fit ? fin[SAMPLE_BITS-1:0]
                   : (fin[FIN_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS - 1){1'b1}}});

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= fin_sat;
            r_clip     <= !fin_fit;
        end
    end

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_vocoded_out   = r_out_data;
    assign o_clipped       = r_clip;

endmodule

>>> rtl/core/channel_vocoder_filter_bank.sv
`timescale 1ns / 1ps
// Channel vocoder, 24 bands: top level joining sequencer and datapath.
//
// Input channel (i_in_valid / o_in_stall): one beat is a request. A sample
// pair starts a pass over all bands; a coefficient write or a clear takes
// effect in the cycle it is accepted and gives no output beat.
// Output channel (o_out_valid / i_out_stall): one beat per sample pair,
// the saturated vocoded sample and its clip flag.
// After a sample pair is accepted, one shared multiplier does nine
// products per band, band after band; then the high and low halves of the
// band sum are scaled by the gain, and the output register is loaded. The
// next request is taken in the cycle after the result has been loaded, so
// no new sample pair is taken before the last one's result is loaded.
// When the receiver stalls, the finished result waits in the output
// register, and a following sample pair is taken and computed; its result
// holds in the accumulator, with the input stalled, until the output register frees.
// Reset (synchronous, active low) empties the output, zeroes coefficients,
// filter histories and envelopes, and loads the default envelope pole and
// unity gain. Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data.
module channel_vocoder_filter_bank (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic                                    i_cfg_idx,
    input  logic [cvfb_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic [1:0]                              i_req_type,
    input  logic signed [cvfb_pkg::SAMPLE_BITS-1:0] i_modulator_in,
    input  logic signed [cvfb_pkg::SAMPLE_BITS-1:0] i_carrier_in,
    input  logic [cvfb_pkg::BAND_W-1:0]             i_coef_band,
    input  logic [1:0]                              i_coef_select,
    input  logic signed [cvfb_pkg::COEF_BITS-1:0]   i_coef_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [cvfb_pkg::SAMPLE_BITS-1:0] o_vocoded_out,
    output logic                                    o_clipped
);
    import cvfb_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     busy;
    logic     accept;

    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    cvfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    cvfb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_accept       (accept),
        .i_req_type     (i_req_type),
        .i_modulator_in (i_modulator_in),
        .i_carrier_in   (i_carrier_in),
        .i_coef_band    (i_coef_band),
        .i_coef_select  (i_coef_select),
        .i_coef_value   (i_coef_value),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_vocoded_out  (o_vocoded_out),
        .o_clipped      (o_clipped)
    );

endmodule
